### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/qbr_pkg.sv
// Shared constants, types and helpers of the quantization breakpoint remapper.
package qbr_pkg;

   localparam int MAX_BITS   = 16;
   localparam int BITS_W     = 5;
   localparam int COUNT_W    = 17;
   localparam int BP_W       = 16;
   localparam int MAP_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_NUM_W  = 35;
   localparam int DIV_DEN_W  = 17;
   localparam int DIV_REM_W  = DIV_DEN_W + 1;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OLD_BITS   = 2'd0,
      CSR_NEW_BITS   = 2'd1,
      CSR_BP_COUNT   = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   // Depths of zero act as one, depths above the maximum act as the maximum.
   function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
      logic [BITS_W-1:0] r;
      r = b;
      if (b == '0) r = BITS_W'(1);
      else if (b > BITS_W'(MAX_BITS)) r = BITS_W'(MAX_BITS);
      return r;
   endfunction

endpackage

### sv/qbr_req_if.sv
// Input channel: one table breakpoint per item.
interface qbr_req_if;
   import qbr_pkg::*;

   logic             valid;
   logic             ready;
   logic [BP_W-1:0]  bp_index;
   logic [BP_W-1:0]  old_breakpoint;
   logic [MAP_W-1:0] map_value;

   modport source (output valid, output bp_index, output old_breakpoint,
                   output map_value, input ready);
   modport sink   (input valid, input bp_index, input old_breakpoint,
                   input map_value, output ready);
endinterface

### sv/qbr_rsp_if.sv
// Result channel: one remapped breakpoint per item.
interface qbr_rsp_if;
   import qbr_pkg::*;

   logic             valid;
   logic             ready;
   logic [BP_W-1:0]  new_breakpoint;
   logic [MAP_W-1:0] map_value_out;
   logic             status;

   modport source (output valid, output new_breakpoint, output map_value_out,
                   output status, input ready);
   modport sink   (input valid, input new_breakpoint, input map_value_out,
                   input status, output ready);
endinterface

### sv/qbr_divider.sv
// Iterative restoring divider: one quotient bit per cycle.
module qbr_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  qbr_pkg::div_req_type div_req,
   output qbr_pkg::div_rsp_type div_rsp
);
   import qbr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_REM_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_REM_W-1:0] rem_shift;

   assign rem_shift = {rem_ff[DIV_REM_W-2:0], quo_ff[DIV_NUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         // trial subtract, keep the bit when it fits
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_shift - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### sv/quant_breakpoint_remap_top.sv
// Quantization table breakpoint remapper between bit depths.
//
// Items enter on req_ch (index, old breakpoint, map value) and leave on rsp_ch
// (new breakpoint, map value, status), one result per item, in order.
// Index zero starts a new table. Depths and breakpoint count are written on
// the csr_ port (index 0 old depth, 1 new depth, 2 count) between tables.
// A rescaled breakpoint goes from accept to result through ST_LOAD, which
// starts the divider, ST_DIV, in which the divider makes one quotient bit
// per cycle over a 35-bit dividend and then raises done, ST_CLAMP (range
// clamp), ST_ORDER (ordering) and ST_OUT, which loads the output register.
// Equal depths and the too-many-breakpoints error skip the divider; their
// result goes from ST_IDLE straight to ST_OUT. One item is in work at a
// time; req_ch.ready is low from accept until the result enters the output
// register, which holds a result while rsp_ch.ready is low; the next item
// may be accepted and worked on meanwhile, and it waits to be loaded there.
// Reset is synchronous: depths return to 8, count to 2, no previous
// breakpoint is held, and both channels go idle.
`include "assert_macros.svh"

module quant_breakpoint_remap_top (
   input  logic                               clock,
   input  logic                               reset,
   qbr_req_if.sink                            req_ch,
   qbr_rsp_if.source                          rsp_ch,
   input  logic                               csr_write_en,
   input  logic [qbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qbr_pkg::COUNT_W-1:0]        csr_write_data
);
   import qbr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_CLAMP,
      ST_ORDER,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [BITS_W-1:0]    old_bits_ff, old_bits_in;
   logic [BITS_W-1:0]    new_bits_ff, new_bits_in;
   logic [COUNT_W-1:0]   bp_count_ff, bp_count_in;
   logic [BITS_W-1:0]    ob_ff, ob_in;
   logic [BITS_W-1:0]    nb_ff, nb_in;
   logic [BP_W-1:0]      p_ff, p_in;
   logic [MAP_W-1:0]     map_ff, map_in;
   logic [COUNT_W-1:0]   remain_ff, remain_in;
   logic [BP_W-1:0]      pval_ff, pval_in;
   logic                 err_ff, err_in;
   logic [BP_W-1:0]      prev_val_ff, prev_val_in;
   logic                 prev_vld_ff, prev_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BP_W-1:0]      rsp_bp_ff, rsp_bp_in;
   logic [MAP_W-1:0]     rsp_map_ff, rsp_map_in;
   logic                 rsp_status_ff, rsp_status_in;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic [BITS_W-1:0]    ob_c, nb_c;
   logic [COUNT_W-1:0]   newlen_c;
   logic [COUNT_W-1:0]   newlen;
   logic [COUNT_W-1:0]   limit;
   logic [COUNT_W-1:0]   top;
   logic [COUNT_W-1:0]   cand;
   logic [BP_W-1:0]      den;
   logic [DIV_NUM_W-1:0] prod;
   logic                 accept;
   logic                 out_free;

   assign ob_c     = clamp_bits(old_bits_ff);
   assign nb_c     = clamp_bits(new_bits_ff);
   assign newlen_c = COUNT_W'(1) << nb_c;
   assign newlen   = COUNT_W'(1) << nb_ff;
   assign limit    = newlen - remain_ff;
   assign top      = newlen - COUNT_W'(1);
   assign cand     = {1'b0, prev_val_ff} + COUNT_W'(1);
   assign den      = BP_W'((COUNT_W'(1) << ob_ff) - COUNT_W'(1));
   // p * (2^nb - 1) as shift and subtract
   assign prod     = (DIV_NUM_W'(p_ff) << nb_ff) - DIV_NUM_W'(p_ff);

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign div_req.start    = (state_ff == ST_LOAD);
   assign div_req.dividend = {prod[DIV_NUM_W-2:0], 1'b0} + DIV_NUM_W'(den);
   assign div_req.divisor  = {den, 1'b0};

   qbr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      old_bits_in   = old_bits_ff;
      new_bits_in   = new_bits_ff;
      bp_count_in   = bp_count_ff;
      ob_in         = ob_ff;
      nb_in         = nb_ff;
      p_in          = p_ff;
      map_in        = map_ff;
      remain_in     = remain_ff;
      pval_in       = pval_ff;
      err_in        = err_ff;
      prev_val_in   = prev_val_ff;
      prev_vld_in   = prev_vld_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_bp_in     = rsp_bp_ff;
      rsp_map_in    = rsp_map_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_OLD_BITS: old_bits_in = csr_write_data[BITS_W-1:0];
            CSR_NEW_BITS: new_bits_in = csr_write_data[BITS_W-1:0];
            CSR_BP_COUNT: bp_count_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ob_in  = ob_c;
               nb_in  = nb_c;
               p_in   = req_ch.old_breakpoint;
               map_in = req_ch.map_value;
               remain_in = (bp_count_ff > {1'b0, req_ch.bp_index}) ?
                           bp_count_ff - {1'b0, req_ch.bp_index} : COUNT_W'(1);
               if (req_ch.bp_index == '0) prev_vld_in = 1'b0;
               if (ob_c == nb_c) begin
                  // equal depths: pass through without clamping
                  pval_in     = req_ch.old_breakpoint;
                  err_in      = 1'b0;
                  prev_val_in = req_ch.old_breakpoint;
                  prev_vld_in = 1'b1;
                  state_in    = ST_OUT;
               end else if (bp_count_ff > newlen_c) begin
                  pval_in  = '0;
                  err_in   = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            // leave room for the breakpoints still to come
            if (div_rsp.quotient > DIV_NUM_W'(limit)) pval_in = limit[BP_W-1:0];
            else pval_in = div_rsp.quotient[BP_W-1:0];
            state_in = ST_ORDER;
         end
         ST_ORDER: begin
            // force strictly above the previous breakpoint, saturate at the top
            if (prev_vld_ff && (pval_ff <= prev_val_ff)) begin
               pval_in     = (cand > top) ? top[BP_W-1:0] : cand[BP_W-1:0];
               prev_val_in = (cand > top) ? top[BP_W-1:0] : cand[BP_W-1:0];
            end else begin
               prev_val_in = pval_ff;
            end
            prev_vld_in = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bp_in     = pval_ff;
               rsp_map_in    = err_ff ? '0 : map_ff;
               rsp_status_in = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         old_bits_ff  <= BITS_W'(8);
         new_bits_ff  <= BITS_W'(8);
         bp_count_ff  <= COUNT_W'(2);
         prev_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         old_bits_ff  <= old_bits_in;
         new_bits_ff  <= new_bits_in;
         bp_count_ff  <= bp_count_in;
         prev_vld_ff  <= prev_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ob_ff         <= ob_in;
      nb_ff         <= nb_in;
      p_ff          <= p_in;
      map_ff        <= map_in;
      remain_ff     <= remain_in;
      pval_ff       <= pval_in;
      err_ff        <= err_in;
      prev_val_ff   <= prev_val_in;
      rsp_bp_ff     <= rsp_bp_in;
      rsp_map_ff    <= rsp_map_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.new_breakpoint = rsp_bp_ff;
   assign rsp_ch.map_value_out  = rsp_map_ff;
   assign rsp_ch.status         = rsp_status_ff;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ch.ready,
      "input still ready after an item was accepted")
   `ASSERT_IMPL(a_error_zero_payload, clock, reset, rsp_ch.valid && rsp_ch.status,
      (rsp_ch.new_breakpoint == '0) && (rsp_ch.map_value_out == '0),
      "error result carries a nonzero payload")
   `ASSERT_IMPL(a_done_in_div, clock, reset, div_rsp.done, state_ff == ST_DIV,
      "divider finished outside the divide state")
   `ASSERT_IMPL(a_div_idle_outside, clock, reset,
      (state_ff == ST_IDLE) || (state_ff == ST_OUT), !div_rsp.busy,
      "divider busy while no division is pending")

endmodule

### tb/sv/quant_breakpoint_remap_top_tb.sv
// Self-checking testbench of the breakpoint remapper: predicts every item and checks each result.

typedef struct packed {
   logic [qbr_pkg::BP_W-1:0]  new_bp;
   logic [qbr_pkg::MAP_W-1:0] map_out;
   logic                      status;
} remap_result_type;

class bp_remap_scoreboard;
   logic [qbr_pkg::BITS_W-1:0]  old_bits;
   logic [qbr_pkg::BITS_W-1:0]  new_bits;
   logic [qbr_pkg::COUNT_W-1:0] bp_count;
   longint                      last_bp;
   remap_result_type            expected_remaps[$];
   int                          mismatches;
   int                          results_seen;
   int                          error_results;

   function new();
      old_bits      = 8;
      new_bits      = 8;
      bp_count      = 2;
      last_bp       = -1;
      mismatches    = 0;
      results_seen  = 0;
      error_results = 0;
   endfunction

   // Zero acts as one, anything past the maximum acts as the maximum.
   function int unsigned eff_depth(logic [qbr_pkg::BITS_W-1:0] b);
      if (b == 0) return 1;
      if (b > qbr_pkg::MAX_BITS) return qbr_pkg::MAX_BITS;
      return int'(b);
   endfunction

   function void write_reg(qbr_pkg::csr_index_type idx, logic [qbr_pkg::COUNT_W-1:0] data);
      case (idx)
         qbr_pkg::CSR_OLD_BITS: old_bits = data[qbr_pkg::BITS_W-1:0];
         qbr_pkg::CSR_NEW_BITS: new_bits = data[qbr_pkg::BITS_W-1:0];
         qbr_pkg::CSR_BP_COUNT: bp_count = data;
         default: ;
      endcase
   endfunction

   function void note_breakpoint(logic [qbr_pkg::BP_W-1:0] idx, logic [qbr_pkg::BP_W-1:0] p,
                                 logic [qbr_pkg::MAP_W-1:0] map);
      int unsigned       ob;
      int unsigned       nb;
      longint unsigned   top;
      longint unsigned   den;
      longint unsigned   remain;
      longint unsigned   scaled;
      longint unsigned   pu;
      remap_result_type  r;
      ob = eff_depth(old_bits);
      nb = eff_depth(new_bits);
      top = 64'd1 << nb;
      pu = p;
      r = '0;
      if (idx == 0) last_bp = -1;
      if (ob == nb) begin
         last_bp = pu;
         r.new_bp = p;
         r.map_out = map;
      end else if (bp_count > top) begin
         // too many breakpoints: last_bp stays as set above
         r.status = 1'b1;
      end else begin
         den = (64'd1 << ob) - 1;
         scaled = (2 * pu * (top - 1) + den) / (2 * den);
         remain = (bp_count > idx) ? bp_count - idx : 64'd1;
         // leave room for the breakpoints still to come
         if (scaled + remain > top) scaled = top - remain;
         if (last_bp >= 0 && scaled <= $unsigned(last_bp)) begin
            scaled = last_bp + 1;
            if (scaled > top - 1) scaled = top - 1;
         end
         last_bp = scaled;
         r.new_bp = scaled[qbr_pkg::BP_W-1:0];
         r.map_out = map;
      end
      expected_remaps.push_back(r);
   endfunction

   function void check_remap(logic [qbr_pkg::BP_W-1:0] bp, logic [qbr_pkg::MAP_W-1:0] map,
                             logic st);
      remap_result_type want;
      results_seen++;
      if (expected_remaps.size() == 0) begin
         $display("%0t: result with no item pending: new_breakpoint %0d map %h status %0b",
                  $time, bp, map, st);
         mismatches++;
         return;
      end
      want = expected_remaps.pop_front();
      if (st === 1'b1) error_results++;
      if (bp !== want.new_bp) begin
         $display("%0t: new_breakpoint expected %0d actual %0d", $time, want.new_bp, bp);
         mismatches++;
      end
      if (map !== want.map_out) begin
         $display("%0t: map_value_out expected %h actual %h", $time, want.map_out, map);
         mismatches++;
      end
      if (st !== want.status) begin
         $display("%0t: status expected %0b actual %0b", $time, want.status, st);
         mismatches++;
      end
   endfunction
endclass

module quant_breakpoint_remap_top_tb;
   import qbr_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 60;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COUNT_W-1:0]   csr_write_data;

   qbr_req_if req_ch();
   qbr_rsp_if rsp_ch();

   bp_remap_scoreboard remap_sb;
   bit                 gaps_on = 1'b1;
   bit                 stalls_on = 1'b1;
   int                 items_sent = 0;
   int                 settings_used = 0;
   int                 cycle_count = 0;

   quant_breakpoint_remap_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** quant_breakpoint_remap_top: FAILED **");
         $finish;
      end
   end

   task automatic send_bp(input int unsigned idx, input int unsigned p,
                          input logic [MAP_W-1:0] map);
      int gap;
      gap = gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.bp_index       <= BP_W'(idx);
      req_ch.old_breakpoint <= BP_W'(p);
      req_ch.map_value      <= map;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      remap_sb.note_breakpoint(BP_W'(idx), BP_W'(p), map);
      items_sent++;
   endtask

   // Hold the sender off until every result of the phase is back.
   task automatic finish_phase();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (remap_sb.expected_remaps.size() != 0);
   endtask

   task automatic configure(input int unsigned ob, input int unsigned nb,
                            input int unsigned cnt);
      csr_index_type      regs [4];
      logic [COUNT_W-1:0] vals [4];
      regs = '{CSR_OLD_BITS, CSR_NEW_BITS, CSR_BP_COUNT, CSR_UNUSED};
      vals = '{COUNT_W'(ob), COUNT_W'(nb), COUNT_W'(cnt), COUNT_W'($urandom)};
      for (int k = 0; k < 4; k++) begin
         csr_write_en   <= 1'b1;
         csr_index      <= regs[k];
         csr_write_data <= vals[k];
         @(posedge clock);
         remap_sb.write_reg(regs[k], vals[k]);
      end
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // Breakpoints stepping up across the old range; long tables send their head and tail only.
   task automatic send_table(input int unsigned cnt, input int unsigned depth);
      int unsigned span;
      int unsigned step;
      int unsigned bp;
      int unsigned n;
      int unsigned idx;
      span = (1 << depth) - 1;
      n = (cnt >= 1 && cnt <= 24) ? cnt : 6;
      step = 2 * span / ((cnt > 0) ? cnt : 1) + 1;
      bp = $urandom_range(0, step);
      for (int unsigned i = 0; i < n; i++) begin
         idx = (cnt > 24 && i >= 3) ? cnt - n + i : i;
         if (cnt > 24 && i == 3) bp = span - $urandom_range(0, 3);
         if (bp > 65535) bp = 65535;
         send_bp(idx, bp, $urandom);
         bp += $urandom_range(0, step);
      end
   endtask

   initial begin : rsp_side
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = stalls_on ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         remap_sb.check_remap(rsp_ch.new_breakpoint, rsp_ch.map_value_out, rsp_ch.status);
      end
   end

   initial begin : req_side
      int          random_base;
      int unsigned ob;
      int unsigned nb;
      int unsigned top;
      int unsigned cnt;
      int unsigned pick;
      remap_sb = new();
      reset                 <= 1'b1;
      csr_write_en          <= 1'b0;
      csr_index             <= CSR_OLD_BITS;
      csr_write_data        <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.bp_index       <= '0;
      req_ch.old_breakpoint <= '0;
      req_ch.map_value      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // equal depths out of reset
      send_bp(0, 0, 32'h0000_0000);
      send_bp(1, 65535, 32'hFFFF_FFFF);
      finish_phase();
      // widen
      configure(8, 16, 256);
      send_bp(0, 0, $urandom);
      send_bp(1, 255, $urandom);
      send_bp(5, 128, $urandom);
      finish_phase();
      // narrow: end clamp, index past count, forced increase saturating at the top
      configure(16, 8, 256);
      send_bp(0, 65535, $urandom);
      send_bp(300, 65535, $urandom);
      send_bp(3, 10, $urandom);
      finish_phase();
      // too many breakpoints
      configure(4, 2, 5);
      send_bp(0, 3, $urandom);
      send_bp(1, 15, $urandom);
      finish_phase();
      // depths out of range, full count
      configure(0, 31, 65536);
      send_bp(0, 1, $urandom);
      send_bp(65535, 1, $urandom);
      send_bp(65534, 0, $urandom);
      finish_phase();
      configure(31, 0, 1);
      send_bp(0, 32768, $urandom);
      send_bp(0, 32767, $urandom);
      finish_phase();
      // zero count, breakpoint above the old range
      configure(3, 5, 0);
      send_bp(0, 7, $urandom);
      send_bp(2, 9, $urandom);
      finish_phase();
      configure(5, 3, 131071);
      send_bp(0, 4, $urandom);
      finish_phase();
      // zero and one both act as one: pass through
      configure(0, 1, 3);
      send_bp(0, 65535, $urandom);
      finish_phase();

      random_base = items_sent;
      while (items_sent < random_base + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            ob = $urandom_range(0, 31);
            nb = $urandom_range(0, 31);
         end else begin
            ob = $urandom_range(1, 16);
            nb = (pick == 1) ? ob : $urandom_range(1, 16);
         end
         top = 1 << remap_sb.eff_depth(BITS_W'(nb));
         pick = $urandom_range(0, 9);
         if (pick == 0) cnt = $urandom_range(0, 131071);
         else if (pick == 1) cnt = top;
         else cnt = $urandom_range(1, (top < 16) ? top : 16);
         configure(ob, nb, cnt);
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 3)) send_table(cnt, remap_sb.eff_depth(BITS_W'(ob)));
         // noise: arbitrary index and breakpoint
         repeat ($urandom_range(0, 4))
            send_bp($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (remap_sb.expected_remaps.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, remap_sb.expected_remaps.size());
         remap_sb.mismatches++;
      end
      $display("Remapped %0d items over %0d depth/count settings, %0d results checked.",
               items_sent, settings_used, remap_sb.results_seen);
      $display("%0d results flagged too many breakpoints; %0d mismatches.",
               remap_sb.error_results, remap_sb.mismatches);
      if (remap_sb.mismatches == 0) begin
         $display("** quant_breakpoint_remap_top: PASSED **");
      end else begin
         $display("** quant_breakpoint_remap_top: FAILED **");
      end
      $finish;
   end
endmodule
